@@ src/gia_pkg.sv @@
// Shared constants, codes and control types for the generational ID allocator.
package gia_pkg;

   // Geometry of a handle and of the free ring.
   localparam int ID_BITS    = 24;
   localparam int FREE_DEPTH = 64;
   localparam int PTR_W      = $clog2(FREE_DEPTH);
   localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
   localparam int FRESH_W    = ID_BITS + 1;

   localparam logic [31:0]      AGE_STEP  = 32'(1) << ID_BITS;
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FREE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FREE_DEPTH);
   localparam logic [FRESH_W-1:0] FRESH_FIRST = FRESH_W'(1);

   // Request kinds carried in the input tuser.
   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   // Result status carried in the output tuser.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_RING_FULL = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the accepted request
      logic commit;   // update state and load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;  // result register can take a new result this cycle
   } dp_status_type;

endpackage

@@ src/generational_id_allocator.sv @@
// Result path: an accepted request is captured, then executed into the result register
// once that register is free, so an earlier result still waiting there delays it.
// Flow: capture, then execute with the ring's registered read port; no new request is
// taken until the captured one commits, but one is taken while a result waits.
// Reset: synchronous, active high; clears ring pointers, count and result valid, sets the
// fresh index counter to one. Ring contents are not cleared and need no pass.
module generational_id_allocator import gia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] handle_in
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] handle_out
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   gia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gia_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_tuser),
      .req_handle (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_handle (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

@@ src/gia_ctrl.sv @@
// Controller state machine that sequences request capture and commit.
module gia_ctrl import gia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type sts
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_tready_ff;
   logic      req_tready_in;
   logic      req_fire;

   assign req_fire   = req_tvalid && req_tready_ff;
   assign req_tready = req_tready_ff;

   // Commands follow from the state, the request handshake and the datapath status.
   always_comb begin
      cmd.capture = req_fire;
      cmd.commit  = (state_ff == S_EXEC) && sts.slot_free;
   end

   // Next state: take one transaction, then commit once the result register frees up.
   always_comb begin
      state_in      = state_ff;
      req_tready_in = req_tready_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in      = S_EXEC;
               req_tready_in = 1'b0;
            end
         end
         S_EXEC: begin
            if (sts.slot_free) begin
               state_in      = S_IDLE;
               req_tready_in = 1'b1;
            end
         end
         default: begin
            state_in      = S_IDLE;
            req_tready_in = 1'b1;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         req_tready_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         req_tready_ff <= req_tready_in;
      end
   end

endmodule

@@ src/gia_dp.sv @@
// Datapath: free ring memory, ring pointers, fresh index counter and result register.
module gia_dp import gia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic          req_func,
   input  logic [31:0]   req_handle,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_handle,
   output logic [1:0]    rsp_status
);

   logic [31:0]        ring_mem [FREE_DEPTH];
   logic [31:0]        rd_data_ff;

   logic               func_ff;
   logic [31:0]        handle_ff;

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FRESH_W-1:0] fresh_ff, fresh_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_handle_ff, rsp_handle_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               ring_wr;
   logic               ring_empty;
   logic               ring_full;

   assign ring_empty    = (count_ff == '0);
   assign ring_full     = (count_ff == CNT_FULL);
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         handle_ff <= req_handle;
      end
   end

   // Ring memory: the head entry is read every cycle, so it is ready when the
   // captured request executes; the head does not move in between.
   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[head_ff];
      if (ring_wr) begin
         ring_mem[tail_ff] <= handle_ff;
      end
   end

   // Execute the captured transaction.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      ring_wr       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = '0;
         rsp_status_in = ST_OK;
         if (func_ff == FUNC_ALLOC) begin
            if (!ring_empty) begin
               rsp_handle_in = rd_data_ff + AGE_STEP;
               head_in       = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
               count_in      = count_ff - CNT_W'(1);
            end else if (!fresh_ff[ID_BITS]) begin
               rsp_handle_in = 32'(fresh_ff);
               fresh_in      = fresh_ff + FRESH_W'(1);
            end else begin
               rsp_status_in = ST_EXHAUSTED;
            end
         end else begin
            if (ring_full) begin
               rsp_status_in = ST_RING_FULL;
            end else begin
               ring_wr  = 1'b1;
               tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= FRESH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ tb/generational_id_allocator_test.sv @@
// Self-checking testbench for the generational ID allocator stream block.
module generational_id_allocator_test import gia_pkg::*;;

   // Run limits: the cycle ceiling covers every item waiting out the longest
   // sender gap and the longest receiver stall several times over.
   localparam int CYCLE_LIMIT = 400000;
   localparam int END_CYCLES  = 8;
   localparam logic [FRESH_W-1:0] FRESH_LIMIT = FRESH_W'(1) << ID_BITS;

   // One allocator response as the block should return it.
   typedef struct {
      logic [31:0] handle;
      status_type  status;
   } handle_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] handle_in
   logic        req_tuser = 1'b0; // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] handle_out
   logic [1:0]  rsp_tuser;        // [1:0] status

   // Shadow allocator state and the responses still owed by the block.
   logic [FRESH_W-1:0] next_fresh_index = FRESH_FIRST;
   logic [31:0]        freed_handles[$];
   handle_result_type  pending_results[$];

   int  failure_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  req_idle_enable = 1'b0;
   bit  rsp_idle_enable = 1'b0;

   generational_id_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_idle(input bit enable);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enable || roll < 60) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Work out the response to one accepted request and update the shadow state.
   task automatic predict_handle_result(input func_type func, input logic [31:0] handle);
      handle_result_type res;
      res.handle = '0;
      res.status = ST_OK;
      if (func == FUNC_ALLOC) begin
         if (freed_handles.size() != 0) begin
            // Oldest freed handle comes back one age step older, wrapping at 32 bits.
            res.handle = freed_handles.pop_front() + AGE_STEP;
         end else if (next_fresh_index < FRESH_LIMIT) begin
            res.handle = 32'(next_fresh_index);
            next_fresh_index = next_fresh_index + 1'b1;
         end else begin
            next_fresh_index = FRESH_LIMIT;
            res.status = ST_EXHAUSTED;
         end
      end else if (freed_handles.size() >= FREE_DEPTH) begin
         res.status = ST_RING_FULL;
      end else begin
         freed_handles.push_back(handle);
      end
      pending_results.push_back(res);
   endtask

   // Offer one request after a random gap and wait for its transaction.
   task automatic send_request(input func_type func, input logic [31:0] handle);
      int gap;
      gap = pick_idle(req_idle_enable);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= handle;
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_handle_result(func, handle);
   endtask

   // Stop sending and wait until every owed response has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Fresh indices are handed out in order starting at one.
   task automatic test_fresh_indices();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      repeat (3) send_request(FUNC_ALLOC, $urandom());
   endtask

   // Extreme handles go through the ring and return aged, including the wrap.
   task automatic test_handle_extremes();
      logic [31:0] extremes[6];
      int k;
      extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h00FF_FFFF, 32'hFF00_0005};
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      for (k = 0; k < 6; k++) send_request(FUNC_FREE, extremes[k]);
      for (k = 0; k < 6; k++) send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
      // Ring is empty again, so the next one is fresh.
      send_request(FUNC_ALLOC, 32'h0);
      send_request(FUNC_FREE, 32'h0000_0002);
      send_request(FUNC_ALLOC, 32'h0);
      send_request(FUNC_ALLOC, 32'h0);
   endtask

   // Fill the ring past its depth, move the pointers off zero and refill across
   // the wrap, then drain it completely and fall back to fresh indices.
   task automatic test_ring_overflow();
      int k;
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b0;
      for (k = 0; k < FREE_DEPTH + 4; k++) send_request(FUNC_FREE, $urandom());
      for (k = 0; k < 10; k++) send_request(FUNC_ALLOC, $urandom());
      for (k = 0; k < 14; k++) send_request(FUNC_FREE, $urandom());
      wait_for_drain();
      rsp_idle_enable = 1'b1;
      for (k = 0; k < FREE_DEPTH + 6; k++) send_request(FUNC_ALLOC, $urandom());
   endtask

   // Blocks of random traffic, each with its own mix of frees and idling.
   task automatic test_random_traffic();
      int blk;
      int k;
      int free_percent;
      for (blk = 0; blk < 20; blk++) begin
         case ($urandom_range(0, 2))
            0: free_percent = 50;
            1: free_percent = 80;
            default: free_percent = 20;
         endcase
         req_idle_enable = ($urandom_range(0, 3) != 0);
         rsp_idle_enable = ($urandom_range(0, 3) != 0);
         for (k = 0; k < 50; k++) begin
            if ($urandom_range(0, 99) < free_percent) begin
               send_request(FUNC_FREE, $urandom());
            end else begin
               send_request(FUNC_ALLOC, $urandom());
            end
         end
         if (blk % 5 == 4) begin
            wait_for_drain();
         end
      end
   endtask

   // Test sequence.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fresh_indices();
      test_handle_extremes();
      test_ring_overflow();
      test_random_traffic();
      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (failure_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Response checking and random back-pressure on the result channel.
   always @(posedge clock) begin : check_results
      handle_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: handle_out %h status %0d", rsp_tdata, rsp_tuser);
            failure_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.handle) begin
               $error("handle_out: expected %h, actual %h", want.handle, rsp_tdata);
               failure_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               failure_count++;
            end
         end
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_idle(rsp_idle_enable);
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
